// ----- rtl/core/awk_pkg.sv -----
// shared types and constants for the archive block header walker
// item and result payloads, configuration indexes and field widths
// no dependencies
package awk_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 48;
  localparam int unsigned OFS_OUT_W       = 48;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE  = CFG_IDX_W'(1);

  localparam logic [7:0] START_OFFSET_RST = 8'd8;
  localparam logic [7:0] TARGET_TYPE_RST  = 8'd3;

  localparam logic [63:0] SKIP_FOREVER = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic KIND_BLOCK   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_OVERRUN = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic                 record_kind;
    logic                 status;
    logic [OFS_OUT_W-1:0] block_offset;
    logic [OFS_OUT_W-1:0] header_end;
    logic [7:0]           block_type;
    logic [63:0]          block_flags;
    logic [63:0]          extra_size;
    logic [63:0]          data_size;
    logic                 target_found;
    logic                 last_result;
  } res_item_t;

  typedef struct packed {
    logic [7:0] start_offset;
    logic [7:0] target_type;
  } cfg_t;

  // up to two results per accepted request, record first
  typedef struct packed {
    logic      rec_v;
    logic      sum_v;
    res_item_t rec;
    res_item_t sum;
  } push_t;

endpackage

// ----- rtl/core/awk_chan_if.sv -----
// valid/ready channel carrying one payload of type T
// depends on nothing; payload types come from awk_pkg at the instance
interface awk_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/awk_parse.sv -----
// byte-wise block header walker: walk state, field decode, result building
// depends on awk_pkg
module awk_parse #(
  parameter int unsigned OFFSET_BITS = awk_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  awk_pkg::in_item_t in_item,
  input  awk_pkg::cfg_t    cfg,
  output awk_pkg::push_t   push
);
  import awk_pkg::*;

  typedef enum logic [7:0] {
    PH_PREFIX = 8'b0000_0001,
    PH_CRC    = 8'b0000_0010,
    PH_HSIZE  = 8'b0000_0100,
    PH_TYPE   = 8'b0000_1000,
    PH_FLAGS  = 8'b0001_0000,
    PH_EXTRA  = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_SKIP   = 8'b1000_0000
  } phase_t;

  phase_t                 phase_r,    phase_nxt;
  logic [OFFSET_BITS-1:0] pos_r,      pos_nxt;
  logic [63:0]            vacc_r,     vacc_nxt;
  logic [6:0]             vsh_r,      vsh_nxt;
  logic [1:0]             crc_r,      crc_nxt;
  logic [OFFSET_BITS-1:0] start_r,    start_nxt;
  logic [OFFSET_BITS-1:0] hend_r,     hend_nxt;
  logic [7:0]             type_r,     type_nxt;
  logic [63:0]            flags_r,    flags_nxt;
  logic [63:0]            extra_r,    extra_nxt;
  logic [63:0]            skip_r,     skip_nxt;
  logic [OFFSET_BITS-1:0] tstart_r,   tstart_nxt;
  logic [OFFSET_BITS-1:0] thend_r,    thend_nxt;
  logic [63:0]            tdata_r,    tdata_nxt;
  logic                   tseen_r,    tseen_nxt;

  logic [63:0]            vacc_new;
  logic [6:0]             vsh_new;
  logic                   vdone;
  logic [OFFSET_BITS-1:0] hend_calc;
  logic [63:0]            skip_dec;
  logic [63:0]            fin_data;
  logic [65:0]            fin_sum;
  logic [63:0]            skip_fin;
  logic                   begin_now;
  logic                   fin;
  logic                   ovr;
  logic                   eos;

  function automatic logic [OFS_OUT_W-1:0] to_ofs(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OFS_OUT_W-1:0];
  endfunction

  assign eos = in_item.end_of_stream;

  // one 7-bit group of a little-endian varint, groups past bit 63 dropped
  always_comb begin
    if (vsh_r < 7'd64) begin
      vacc_new = vacc_r | (64'(in_item.data_byte[6:0]) << vsh_r[5:0]);
      vsh_new  = vsh_r + 7'd7;
    end else begin
      vacc_new = vacc_r;
      vsh_new  = vsh_r;
    end
  end

  assign vdone     = !in_item.data_byte[7];
  assign hend_calc = pos_r + OFFSET_BITS'(1) + vacc_new[OFFSET_BITS-1:0];
  assign skip_dec  = skip_r - 64'd1;
  assign fin_data  = (phase_r == PH_DATA) ? vacc_new : 64'd0;
  // rest of header plus data area, saturating; skip_r is non-zero here
  assign fin_sum   = {2'b00, skip_r} + {2'b00, fin_data} - 66'd1;
  assign skip_fin  = (fin_sum[65:64] != 2'b00) ? SKIP_FOREVER : fin_sum[63:0];

  always_comb begin
    phase_nxt  = phase_r;
    vacc_nxt   = vacc_r;
    vsh_nxt    = vsh_r;
    crc_nxt    = crc_r;
    start_nxt  = start_r;
    hend_nxt   = hend_r;
    type_nxt   = type_r;
    flags_nxt  = flags_r;
    extra_nxt  = extra_r;
    skip_nxt   = skip_r;
    tstart_nxt = tstart_r;
    thend_nxt  = thend_r;
    tdata_nxt  = tdata_r;
    tseen_nxt  = tseen_r;
    begin_now  = 1'b0;
    fin        = 1'b0;
    ovr        = 1'b0;
    push       = '0;

    unique case (phase_r)
      PH_PREFIX: begin
        if (64'(pos_r) >= 64'(cfg.start_offset)) begin
          begin_now = 1'b1;
        end
      end
      PH_CRC: begin
        if (crc_r == 2'd3) begin
          crc_nxt   = 2'd0;
          vacc_nxt  = '0;
          vsh_nxt   = '0;
          phase_nxt = PH_HSIZE;
        end else begin
          crc_nxt = crc_r + 2'd1;
        end
      end
      PH_HSIZE: begin
        vacc_nxt = vacc_new;
        vsh_nxt  = vsh_new;
        if (vdone) begin
          hend_nxt  = hend_calc;
          skip_nxt  = vacc_new;
          vacc_nxt  = '0;
          vsh_nxt   = '0;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE, PH_FLAGS, PH_EXTRA, PH_DATA: begin
        if (skip_r == 64'd0) begin
          // field runs past the declared header end: report and stop walking
          ovr       = 1'b1;
          skip_nxt  = SKIP_FOREVER;
          vacc_nxt  = '0;
          vsh_nxt   = '0;
          phase_nxt = PH_SKIP;
        end else begin
          skip_nxt = skip_dec;
          vacc_nxt = vacc_new;
          vsh_nxt  = vsh_new;
          if (vdone) begin
            vacc_nxt = '0;
            vsh_nxt  = '0;
            if (phase_r == PH_TYPE) begin
              type_nxt  = (vacc_new[63:8] != 56'd0) ? 8'hFF : vacc_new[7:0];
              phase_nxt = PH_FLAGS;
            end else if (phase_r == PH_FLAGS) begin
              flags_nxt = vacc_new;
              if (vacc_new[0]) begin
                phase_nxt = PH_EXTRA;
              end else if (vacc_new[1]) begin
                phase_nxt = PH_DATA;
              end else begin
                fin = 1'b1;
              end
            end else if (phase_r == PH_EXTRA) begin
              extra_nxt = vacc_new;
              if (flags_r[1]) begin
                phase_nxt = PH_DATA;
              end else begin
                fin = 1'b1;
              end
            end else begin
              fin = 1'b1;
            end
          end
        end
      end
      PH_SKIP: begin
        if (skip_r == 64'd0) begin
          begin_now = 1'b1;
        end else if (skip_r != SKIP_FOREVER) begin
          skip_nxt = skip_dec;
        end
      end
      default: begin
        phase_nxt = PH_PREFIX;
      end
    endcase

    if (begin_now) begin
      start_nxt = pos_r;
      hend_nxt  = '0;
      type_nxt  = '0;
      flags_nxt = '0;
      extra_nxt = '0;
      crc_nxt   = 2'd1;
      vacc_nxt  = '0;
      vsh_nxt   = '0;
      phase_nxt = PH_CRC;
    end

    if (fin || ovr) begin
      push.rec_v            = 1'b1;
      push.rec.record_kind  = KIND_BLOCK;
      push.rec.status       = ovr ? STAT_OVERRUN : STAT_OK;
      push.rec.block_offset = to_ofs(start_r);
      push.rec.header_end   = to_ofs(hend_r);
      push.rec.block_type   = type_nxt;
      push.rec.block_flags  = flags_nxt;
      push.rec.extra_size   = extra_nxt;
      push.rec.data_size    = fin ? fin_data : 64'd0;
      push.rec.target_found = 1'b0;
    end

    if (fin) begin
      if (type_nxt == cfg.target_type) begin
        tstart_nxt = start_r;
        thend_nxt  = hend_r;
        tdata_nxt  = fin_data;
        tseen_nxt  = 1'b1;
      end
      skip_nxt  = skip_fin;
      phase_nxt = PH_SKIP;
    end

    pos_nxt = pos_r + OFFSET_BITS'(1);

    if (eos) begin
      push.sum_v            = 1'b1;
      push.sum.record_kind  = KIND_SUMMARY;
      push.sum.status       = STAT_OK;
      push.sum.block_offset = to_ofs(tstart_nxt);
      push.sum.header_end   = to_ofs(thend_nxt);
      push.sum.block_type   = cfg.target_type;
      push.sum.block_flags  = 64'd0;
      push.sum.extra_size   = 64'd0;
      push.sum.data_size    = tdata_nxt;
      push.sum.target_found = tseen_nxt;
      push.sum.last_result  = 1'b1;
      // new stream starts at offset zero
      phase_nxt  = PH_PREFIX;
      pos_nxt    = '0;
      vacc_nxt   = '0;
      vsh_nxt    = '0;
      crc_nxt    = '0;
      start_nxt  = '0;
      hend_nxt   = '0;
      type_nxt   = '0;
      flags_nxt  = '0;
      extra_nxt  = '0;
      skip_nxt   = '0;
      tstart_nxt = '0;
      thend_nxt  = '0;
      tdata_nxt  = '0;
      tseen_nxt  = 1'b0;
    end

    push.rec.last_result = push.rec_v && !eos;

    if (!in_fire) begin
      push.rec_v = 1'b0;
      push.sum_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      pos_r    <= '0;
      vacc_r   <= '0;
      vsh_r    <= '0;
      crc_r    <= '0;
      start_r  <= '0;
      hend_r   <= '0;
      type_r   <= '0;
      flags_r  <= '0;
      extra_r  <= '0;
      skip_r   <= '0;
      tstart_r <= '0;
      thend_r  <= '0;
      tdata_r  <= '0;
      tseen_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      vacc_r   <= vacc_nxt;
      vsh_r    <= vsh_nxt;
      crc_r    <= crc_nxt;
      start_r  <= start_nxt;
      hend_r   <= hend_nxt;
      type_r   <= type_nxt;
      flags_r  <= flags_nxt;
      extra_r  <= extra_nxt;
      skip_r   <= skip_nxt;
      tstart_r <= tstart_nxt;
      thend_r  <= thend_nxt;
      tdata_r  <= tdata_nxt;
      tseen_r  <= tseen_nxt;
    end
  end

  a_eos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && eos |=> pos_r == '0 && phase_r == PH_PREFIX && !tseen_r)
    else $error("walk not restarted after end of stream");

  a_overrun_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ovr && !eos |=> phase_r == PH_SKIP && skip_r == SKIP_FOREVER)
    else $error("walk continued after header overrun");

  a_finish_skips: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && fin && !eos |=> phase_r == PH_SKIP)
    else $error("completed header did not enter skip");

  a_vsh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PREFIX |-> vsh_r == 7'd0 && vacc_r == 64'd0)
    else $error("varint accumulator live during prefix");

endmodule

// ----- rtl/core/awk_resq.sv -----
// three-entry result queue, head always at entry 0
// takes up to two results per cycle; depends on awk_pkg
module awk_resq (
  input  logic                clk,
  input  logic                rst_n,
  input  awk_pkg::push_t      push,
  output logic                room,
  output logic                head_valid,
  output awk_pkg::res_item_t  head,
  input  logic                head_ready
);
  import awk_pkg::*;

  res_item_t q_r [3];
  res_item_t q_nxt [3];
  res_item_t sh [3];
  res_item_t first;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base;
  logic [1:0] n_push;
  logic       pop;

  // two free entries needed, a byte may raise a record and a summary
  assign room       = (cnt_r <= 2'd1);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[0];
  assign pop        = head_valid && head_ready;

  always_comb begin
    if (pop) begin
      sh[0] = q_r[1];
      sh[1] = q_r[2];
      sh[2] = q_r[2];
    end else begin
      sh[0] = q_r[0];
      sh[1] = q_r[1];
      sh[2] = q_r[2];
    end
    base   = cnt_r - {1'b0, pop};
    n_push = {1'b0, push.rec_v} + {1'b0, push.sum_v};
    first  = push.rec_v ? push.rec : push.sum;
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = sh[i];
      if (n_push != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = first;
      end
      if (push.rec_v && push.sum_v && 2'(i) == base + 2'd1) begin
        q_nxt[i] = push.sum;
      end
    end
    cnt_nxt = base + n_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.rec_v || push.sum_v) |-> cnt_r <= 2'd1)
    else $error("result queue written without room");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.rec_v && push.sum_v |-> !push.rec.last_result && push.sum.last_result
      && push.sum.record_kind == KIND_SUMMARY)
    else $error("record and summary pair out of order");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push.rec_v && push.sum_v && !pop |=> cnt_r == $past(cnt_r) + 2'd2)
    else $error("result queue lost an entry");

endmodule

// ----- rtl/core/archive_block_header_walker_unit.sv -----
// archive block header walker, top level
// a result is registered into the result queue and offered on out_ch from its head
// throughput: one request per cycle; a request that yields a block record and the
// end summary puts both results into the queue, and in_ch.ready drops while the
// three-entry result queue holds two or more results
// reset: synchronous on rst_n low; walk restarts at offset 0, registers 8 and 3
module archive_block_header_walker_unit #(
  parameter int unsigned OFFSET_BITS = awk_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  awk_chan_if.sink                            in_ch,
  awk_chan_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [awk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [awk_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import awk_pkg::*;

  cfg_t  cfg_r;
  push_t push;
  logic  room;
  logic  in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_offset <= START_OFFSET_RST;
      cfg_r.target_type  <= TARGET_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_OFFSET: cfg_r.start_offset <= cfg_wdata[7:0];
        CFG_TARGET_TYPE:  cfg_r.target_type  <= cfg_wdata[7:0];
      endcase
    end
  end

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;

  awk_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_ch.payload),
    .cfg     (cfg_r),
    .push    (push)
  );

  awk_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_ch.valid),
    .head       (out_ch.payload),
    .head_ready (out_ch.ready)
  );

endmodule

// ----- test/archive_block_header_walker_unit_tb.sv -----
// testbench for archive_block_header_walker_unit: byte streams in, block records out
// depends on awk_pkg, awk_chan_if and the walker rtl; a tracker class predicts records
module archive_block_header_walker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awk_pkg::*;

  localparam int ITEM_GOAL    = 1950;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [2:0] {
    WALK_PREFIX, WALK_CRC, WALK_HSIZE, WALK_TYPE,
    WALK_FLAGS, WALK_EXTRA, WALK_DATA, WALK_SKIP
  } walk_state_t;

  // follows the walk byte by byte and keeps the records still owed by the block
  class header_walk_tracker;
    logic [7:0]           start_offset;
    logic [7:0]           target_type;
    walk_state_t          walk_state;
    logic [OFS_OUT_W-1:0] position;
    logic [63:0]          accum;
    int unsigned          shift;
    int unsigned          crc_count;
    logic [OFS_OUT_W-1:0] blk_start;
    logic [OFS_OUT_W-1:0] hdr_end;
    logic [7:0]           cur_type;
    logic [63:0]          cur_flags;
    logic [63:0]          cur_extra;
    logic [63:0]          skip_left;
    logic [OFS_OUT_W-1:0] tgt_start;
    logic [OFS_OUT_W-1:0] tgt_hdr_end;
    logic [63:0]          tgt_data;
    logic                 tgt_seen;
    res_item_t            step_records[$];
    res_item_t            pending_records[$];
    int                   mismatches;

    function new();
      start_offset = START_OFFSET_RST;
      target_type  = TARGET_TYPE_RST;
      mismatches   = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      walk_state  = WALK_PREFIX;
      position    = '0;
      accum       = '0;
      shift       = 0;
      crc_count   = 0;
      blk_start   = '0;
      hdr_end     = '0;
      cur_type    = '0;
      cur_flags   = '0;
      cur_extra   = '0;
      skip_left   = '0;
      tgt_start   = '0;
      tgt_hdr_end = '0;
      tgt_data    = '0;
      tgt_seen    = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_START_OFFSET) begin
        start_offset = val;
      end else if (idx == CFG_TARGET_TYPE) begin
        target_type = val;
      end
    endfunction

    function int outstanding();
      return pending_records.size();
    endfunction

    // returns 1 on the closing byte of a varint; groups past bit 63 are dropped
    function bit take_group(logic [7:0] c);
      if (shift < 64) begin
        accum = accum | ({57'b0, c[6:0]} << shift);
        shift = shift + 7;
      end
      return !c[7];
    endfunction

    function void clear_varint();
      accum = '0;
      shift = 0;
    endfunction

    function res_item_t make_record(logic kind, logic stat, logic [OFS_OUT_W-1:0] ofs,
                                    logic [OFS_OUT_W-1:0] hend, logic [7:0] typ,
                                    logic [63:0] flg, logic [63:0] ext, logic [63:0] dat,
                                    logic found);
      res_item_t rec;
      rec.record_kind  = kind;
      rec.status       = stat;
      rec.block_offset = ofs;
      rec.header_end   = hend;
      rec.block_type   = typ;
      rec.block_flags  = flg;
      rec.extra_size   = ext;
      rec.data_size    = dat;
      rec.target_found = found;
      rec.last_result  = 1'b0;
      return rec;
    endfunction

    function void open_block(logic [OFS_OUT_W-1:0] p);
      blk_start  = p;
      hdr_end    = '0;
      cur_type   = '0;
      cur_flags  = '0;
      cur_extra  = '0;
      crc_count  = 1;
      clear_varint();
      walk_state = WALK_CRC;
    endfunction

    function void close_block(logic [63:0] dat);
      step_records.push_back(make_record(KIND_BLOCK, STAT_OK, blk_start, hdr_end, cur_type,
                                         cur_flags, cur_extra, dat, 1'b0));
      if (cur_type == target_type) begin
        tgt_start   = blk_start;
        tgt_hdr_end = hdr_end;
        tgt_data    = dat;
        tgt_seen    = 1'b1;
      end
      if (skip_left > SKIP_FOREVER - dat) begin
        skip_left = SKIP_FOREVER;
      end else begin
        skip_left = skip_left + dat;
      end
      walk_state = WALK_SKIP;
    endfunction

    function void take_byte(in_item_t item);
      logic [7:0]           c;
      logic [OFS_OUT_W-1:0] p;
      logic [63:0]          v;
      c = item.data_byte;
      p = position;
      step_records.delete();
      case (walk_state)
        WALK_PREFIX: begin
          if (p >= start_offset) open_block(p);
        end
        WALK_SKIP: begin
          if (skip_left == 0) begin
            open_block(p);
          end else if (skip_left != SKIP_FOREVER) begin
            skip_left = skip_left - 1;
          end
        end
        WALK_CRC: begin
          if (crc_count >= 3) begin
            crc_count  = 0;
            clear_varint();
            walk_state = WALK_HSIZE;
          end else begin
            crc_count = crc_count + 1;
          end
        end
        WALK_HSIZE: begin
          if (take_group(c)) begin
            hdr_end    = p + 1 + accum[OFS_OUT_W-1:0];
            skip_left  = accum;
            clear_varint();
            walk_state = WALK_TYPE;
          end
        end
        default: begin
          if (skip_left == 0) begin
            // field runs past the declared header size: report and stop the walk
            step_records.push_back(make_record(KIND_BLOCK, STAT_OVERRUN, blk_start, hdr_end,
                                               cur_type, cur_flags, cur_extra, '0, 1'b0));
            skip_left  = SKIP_FOREVER;
            clear_varint();
            walk_state = WALK_SKIP;
          end else begin
            skip_left = skip_left - 1;
            if (take_group(c)) begin
              v = accum;
              clear_varint();
              case (walk_state)
                WALK_TYPE: begin
                  cur_type   = (v > 255) ? 8'hff : v[7:0];
                  walk_state = WALK_FLAGS;
                end
                WALK_FLAGS: begin
                  cur_flags = v;
                  if (v[0]) walk_state = WALK_EXTRA;
                  else if (v[1]) walk_state = WALK_DATA;
                  else close_block('0);
                end
                WALK_EXTRA: begin
                  cur_extra = v;
                  if (cur_flags[1]) walk_state = WALK_DATA;
                  else close_block('0);
                end
                default: close_block(v);
              endcase
            end
          end
        end
      endcase
      position = p + 1;
      if (item.end_of_stream) begin
        step_records.push_back(make_record(KIND_SUMMARY, STAT_OK, tgt_start, tgt_hdr_end,
                                           target_type, '0, '0, tgt_data, tgt_seen));
        restart_walk();
      end
      if (step_records.size() > 0) step_records[step_records.size()-1].last_result = 1'b1;
      foreach (step_records[i]) pending_records.push_back(step_records[i]);
    endfunction

    function void diff_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_record(res_item_t got);
      res_item_t want;
      if (pending_records.size() == 0) begin
        $error("record with none expected: %h", got);
        mismatches++;
        return;
      end
      want = pending_records.pop_front();
      diff_field("record_kind", want.record_kind, got.record_kind);
      diff_field("status", want.status, got.status);
      diff_field("block_offset", want.block_offset, got.block_offset);
      diff_field("header_end", want.header_end, got.header_end);
      diff_field("block_type", want.block_type, got.block_type);
      diff_field("block_flags", want.block_flags, got.block_flags);
      diff_field("extra_size", want.extra_size, got.extra_size);
      diff_field("data_size", want.data_size, got.data_size);
      diff_field("target_found", want.target_found, got.target_found);
      diff_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  awk_chan_if #(.T(in_item_t))  in_ch ();
  awk_chan_if #(.T(res_item_t)) out_ch ();

  archive_block_header_walker_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  header_walk_tracker walk;
  logic [7:0]  build_q[$];
  logic [7:0]  hdr_q[$];
  logic [7:0]  cur_start = START_OFFSET_RST;
  logic [7:0]  cur_target = TARGET_TYPE_RST;
  int          items_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          stall_request = 1'b0;

  always #5ns clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // little-endian 7-bit groups; padded adds one redundant zero group
  function automatic void put_varint(logic [63:0] v, bit padded, bit to_hdr);
    logic [63:0] r;
    logic [6:0]  grp;
    logic [7:0]  b;
    bit          pad;
    r   = v;
    pad = padded;
    forever begin
      grp = r[6:0];
      r   = r >> 7;
      if (r == 0 && !pad) begin
        b = {1'b0, grp};
      end else begin
        b = {1'b1, grp};
        if (r == 0) pad = 1'b0;
      end
      if (to_hdr) hdr_q.push_back(b);
      else build_q.push_back(b);
      if (!b[7]) break;
    end
  endfunction

  function automatic void add_block(bit overrun, bit huge);
    logic [63:0] tval;
    logic [63:0] fval;
    logic [63:0] xval;
    logic [63:0] dval;
    logic [1:0]  fbits;
    int          fields_len;
    int          hsize;
    int          r;
    hdr_q.delete();
    r = $urandom_range(0, 99);
    if (r < 45) tval = 64'(cur_target);
    else if (r < 80) tval = 64'($urandom_range(0, 7));
    else if (r < 92) tval = 64'($urandom_range(0, 255));
    else tval = 64'($urandom_range(256, 70000));
    put_varint(tval, $urandom_range(0, 9) == 0, 1'b1);
    if ($urandom_range(0, 19) == 0) begin
      // flags varint longer than 64 bits
      fbits = 2'($urandom);
      hdr_q.push_back({1'b1, 5'($urandom), fbits});
      repeat ($urandom_range(9, 12)) hdr_q.push_back({1'b1, 7'($urandom)});
      hdr_q.push_back({1'b0, 7'($urandom)});
    end else begin
      if ($urandom_range(0, 1)) fval = 64'($urandom_range(0, 3));
      else fval = {$urandom, $urandom};
      fbits = fval[1:0];
      put_varint(fval, $urandom_range(0, 9) == 0, 1'b1);
    end
    if (fbits[0]) begin
      if ($urandom_range(0, 1)) xval = 64'($urandom_range(0, 300));
      else xval = {$urandom, $urandom};
      put_varint(xval, 1'b0, 1'b1);
    end
    dval = '0;
    if (fbits[1]) begin
      if (huge) dval = SKIP_FOREVER - 64'($urandom_range(0, 3));
      else dval = 64'($urandom_range(0, 12));
      put_varint(dval, 1'b0, 1'b1);
    end
    fields_len = hdr_q.size();
    repeat ($urandom_range(0, 3)) hdr_q.push_back(8'($urandom));
    hsize = overrun ? $urandom_range(0, fields_len - 1) : hdr_q.size();
    repeat (4) build_q.push_back(8'($urandom));
    put_varint(64'(hsize), $urandom_range(0, 7) == 0, 1'b0);
    foreach (hdr_q[i]) build_q.push_back(hdr_q[i]);
    if (huge) repeat ($urandom_range(0, 6)) build_q.push_back(8'($urandom));
    else repeat (int'(dval)) build_q.push_back(8'($urandom));
  endfunction

  function automatic void build_stream();
    int kind;
    int nblk;
    int keep;
    build_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 40)) build_q.push_back(8'($urandom));
      return;
    end
    repeat (int'(cur_start)) build_q.push_back(8'($urandom));
    nblk = $urandom_range(1, 5);
    for (int i = 0; i < nblk; i++) begin
      add_block($urandom_range(0, 99) < 8, i == nblk - 1 && $urandom_range(0, 99) < 5);
    end
    // short tail: too few bytes left to complete another block header
    repeat ($urandom_range(0, 3)) build_q.push_back(8'($urandom));
    if (kind < 20) begin
      keep = $urandom_range(1, build_q.size());
      while (build_q.size() > keep) void'(build_q.pop_back());
    end
    if (build_q.size() == 0) build_q.push_back(8'($urandom));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eos);
    if (tx_idle_en && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= {b, eos};
    do @(posedge clk); while (!in_ch.ready);
    walk.take_byte(in_ch.payload);
    items_sent++;
  endtask

  task automatic send_stream();
    foreach (build_q[i]) push_byte(build_q[i], i == build_q.size() - 1);
  endtask

  // sender goes quiet until every owed record is back, then lets the block settle
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (walk.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] so, input logic [7:0] tt,
                              input bit w_so, input bit w_tt);
    if (w_so) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_START_OFFSET;
      cfg_wdata <= so;
      @(posedge clk);
      walk.set_reg(CFG_START_OFFSET, so);
      cur_start = so;
    end
    if (w_tt) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_TARGET_TYPE;
      cfg_wdata <= tt;
      @(posedge clk);
      walk.set_reg(CFG_TARGET_TYPE, tt);
      cur_target = tt;
    end
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (stall_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_request = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) walk.match_record(out_ch.payload);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [7:0] so;
    logic [7:0] tt;
    bit         w_so;
    bit         w_tt;
    int         phase_no;
    int         n_streams;
    int         r;
    walk = new();
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_START_OFFSET;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: record and summary from the same closing flags byte
    build_q = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
                8'hff, 8'h00, 8'hff, 8'h00, 8'h02, 8'h03, 8'h00};
    send_stream();
    settle_block();

    // type 300 saturates onto target 255, then a header too short for its type
    apply_config(8'd0, 8'd255, 1'b1, 1'b1);
    build_q = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h03, 8'hac, 8'h02, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h01, 8'h7f};
    send_stream();
    settle_block();

    // prefix length lowered under the current position mid-stream
    apply_config(8'd200, 8'd3, 1'b1, 1'b1);
    repeat (3) push_byte(8'($urandom), 1'b0);
    settle_block();
    apply_config(8'd1, 8'd3, 1'b1, 1'b0);
    build_q = '{8'haa, 8'h55, 8'haa, 8'h55, 8'h00, 8'h85};
    send_stream();
    settle_block();

    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase_no)
        0: begin so = 8'd0; tt = 8'd0; w_so = 1'b1; w_tt = 1'b1; end
        1: begin so = 8'd255; tt = 8'd255; w_so = 1'b1; w_tt = 1'b1; end
        3: begin so = 8'd255; tt = 8'd0; w_so = 1'b1; w_tt = 1'b1; end
        default: begin
          so = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 40)) :
               8'($urandom_range(0, 10));
          r  = $urandom_range(0, 9);
          tt = (r < 6) ? 8'($urandom_range(0, 7)) :
               (r < 8) ? 8'd255 : 8'($urandom_range(0, 255));
          w_so = 1'($urandom_range(0, 1));
          w_tt = !w_so || ($urandom_range(0, 1) != 0);
        end
      endcase
      apply_config(so, tt, w_so, w_tt);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (phase_no == 2) begin
        // back-to-back minimal headers while the result side holds off
        tx_idle_en    = 1'b0;
        stall_request = 1'b1;
        build_q.delete();
        repeat (int'(cur_start)) build_q.push_back(8'($urandom));
        repeat (30) begin
          repeat (4) build_q.push_back(8'($urandom));
          build_q.push_back(8'h02);
          build_q.push_back(8'($urandom_range(0, 5)));
          build_q.push_back(8'h00);
        end
        send_stream();
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        n_streams  = (cur_start > 100) ? 1 : $urandom_range(2, 5);
        repeat (n_streams) begin
          build_stream();
          send_stream();
        end
      end
      settle_block();
      phase_no++;
    end

    if (walk.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
